### src/rpc_pkg.sv
// ---------------------------------------------------------------------------
// rpc_pkg: shared types and constants for rectangle pixel coverage
// register indexes, draw modes, luma weights and the precomputed box bounds
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

  localparam int MAX_FRAME_WIDTH  = 4096;
  localparam int MAX_FRAME_HEIGHT = 4096;

  localparam int COORD_W = 12;
  localparam int BOUND_W = 18;
  localparam int CFG_W   = 24;
  localparam int ADDR_W  = 3;

  typedef enum logic [ADDR_W-1:0] {
    REG_LEFT      = 3'd0,
    REG_TOP       = 3'd1,
    REG_WIDTH     = 3'd2,
    REG_HEIGHT    = 3'd3,
    REG_THICKNESS = 3'd4,
    REG_COLOR     = 3'd5,
    REG_MODE      = 3'd6
  } rpc_reg_t;

  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;

  localparam logic [15:0] LUMA_R = 16'd13933;
  localparam logic [15:0] LUMA_G = 16'd46871;
  localparam logic [15:0] LUMA_B = 16'd4732;

  // half-open box [xlo,xhi) x [ylo,yhi); empty when hi <= lo
  typedef struct packed {
    logic signed [BOUND_W-1:0] xlo;
    logic signed [BOUND_W-1:0] xhi;
    logic signed [BOUND_W-1:0] ylo;
    logic signed [BOUND_W-1:0] yhi;
  } rpc_box_t;

  typedef struct packed {
    rpc_box_t [3:0] box;
    logic [1:0]     mode;
    logic [23:0]    color;
  } rpc_setup_t;

endpackage

`default_nettype wire

### src/rpc_cfg.sv
// ---------------------------------------------------------------------------
// rpc_cfg: configuration registers and box bound setup
// holds the register file and derives the four band boxes (or the fill box)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rpc_pkg::ADDR_W-1:0]    cfg_addr,
  input  wire logic [rpc_pkg::CFG_W-1:0]     cfg_wdata,
  output rpc_pkg::rpc_setup_t                setup
);

  logic [15:0] left_r, top_r, width_r, height_r;
  logic [9:0]  thick_r;
  logic [23:0] color_r;
  logic [1:0]  mode_r;

  rpc_pkg::rpc_setup_t setup_r, setup_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      thick_r  <= '0;
      color_r  <= 24'hFFFFFF;
      mode_r   <= rpc_pkg::MODE_GRAY;
    end else if (cfg_we) begin
      unique case (rpc_pkg::rpc_reg_t'(cfg_addr))
        rpc_pkg::REG_LEFT:      left_r   <= cfg_wdata[15:0];
        rpc_pkg::REG_TOP:       top_r    <= cfg_wdata[15:0];
        rpc_pkg::REG_WIDTH:     width_r  <= cfg_wdata[15:0];
        rpc_pkg::REG_HEIGHT:    height_r <= cfg_wdata[15:0];
        rpc_pkg::REG_THICKNESS: thick_r  <= cfg_wdata[9:0];
        rpc_pkg::REG_COLOR:     color_r  <= cfg_wdata[23:0];
        rpc_pkg::REG_MODE:      mode_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic signed [rpc_pkg::BOUND_W-1:0] x, y, w, h, th, tr, sxw, syh;

  always_comb begin
    x   = rpc_pkg::BOUND_W'($signed(left_r));
    y   = rpc_pkg::BOUND_W'($signed(top_r));
    w   = rpc_pkg::BOUND_W'($signed(width_r));
    h   = rpc_pkg::BOUND_W'($signed(height_r));
    th  = $signed({9'd0, thick_r[9:1]});
    // ceil(t/2)
    tr  = $signed({8'd0, thick_r}) - th;
    sxw = x + w;
    syh = y + h;

    setup_nxt       = '0;
    setup_nxt.mode  = mode_r;
    setup_nxt.color = color_r;
    if (thick_r == '0) begin
      setup_nxt.box[0] = '{xlo: x, xhi: sxw, ylo: y, yhi: syh};
    end else begin
      // top, bottom, left and right bands of the widened rectangle
      setup_nxt.box[0] = '{xlo: x - th,   xhi: sxw + tr, ylo: y - th,   yhi: y + tr};
      setup_nxt.box[1] = '{xlo: x - th,   xhi: sxw + tr, ylo: syh - th, yhi: syh + tr};
      setup_nxt.box[2] = '{xlo: x - th,   xhi: x + tr,   ylo: y + tr,   yhi: syh - th};
      setup_nxt.box[3] = '{xlo: sxw - th, xhi: sxw + tr, ylo: y + tr,   yhi: syh - th};
    end
  end

  always_ff @(posedge clk) begin
    setup_r <= setup_nxt;
  end

  assign setup = setup_r;

endmodule

`default_nettype wire

### src/rpc_pipe.sv
// ---------------------------------------------------------------------------
// rpc_pipe: four-stage coverage and shading pipeline
// capture, box compare with luma products, hit merge with luma sum, output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_pipe (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rpc_pkg::rpc_setup_t            setup,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rpc_pkg::COORD_W-1:0]    in_x,
  input  wire logic [rpc_pkg::COORD_W-1:0]    in_y,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_paint,
  output logic [7:0]                          out_first,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue
);

  logic run_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = run_r && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      run_r <= 1'b1;
      if (rdy1) v1_r <= in_valid && in_ready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: capture
  logic [rpc_pkg::COORD_W-1:0] x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r <= in_x;
      y1_r <= in_y;
    end
  end

  // stage 2: box compares, frame and mode check, luma products
  logic signed [rpc_pkg::BOUND_W-1:0] pxs, pys;
  logic [3:0]  hit2_nxt, hit2_r;
  logic        ok2_nxt, ok2_r;
  logic [23:0] pr_nxt, pg_nxt, pb_nxt, pr_r, pg_r, pb_r;

  always_comb begin
    pxs = $signed({6'd0, x1_r});
    pys = $signed({6'd0, y1_r});
    for (int i = 0; i < 4; i++) begin
      hit2_nxt[i] = (pxs >= setup.box[i].xlo) && (pxs < setup.box[i].xhi) &&
                    (pys >= setup.box[i].ylo) && (pys < setup.box[i].yhi);
    end
    ok2_nxt = ((setup.mode == rpc_pkg::MODE_GRAY) || (setup.mode == rpc_pkg::MODE_RGB)) &&
              ({5'd0, x1_r} < 17'(rpc_pkg::MAX_FRAME_WIDTH)) &&
              ({5'd0, y1_r} < 17'(rpc_pkg::MAX_FRAME_HEIGHT));
    pr_nxt = {16'd0, setup.color[23:16]} * {8'd0, rpc_pkg::LUMA_R};
    pg_nxt = {16'd0, setup.color[15:8]}  * {8'd0, rpc_pkg::LUMA_G};
    pb_nxt = {16'd0, setup.color[7:0]}   * {8'd0, rpc_pkg::LUMA_B};
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      hit2_r <= hit2_nxt;
      ok2_r  <= ok2_nxt;
      pr_r   <= pr_nxt;
      pg_r   <= pg_nxt;
      pb_r   <= pb_nxt;
    end
  end

  // stage 3: merge hits, luma sum
  logic        paint3_nxt, paint3_r;
  logic [23:0] sum3;
  logic [7:0]  luma3_r;

  always_comb begin
    paint3_nxt = ok2_r && (|hit2_r);
    sum3       = pr_r + pg_r + pb_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      paint3_r <= paint3_nxt;
      luma3_r  <= sum3[23:16];
    end
  end

  // stage 4: output register
  logic       paint4_r;
  logic [7:0] first4_r, green4_r, blue4_r;
  logic [7:0] first4_nxt, green4_nxt, blue4_nxt;
  logic       rgb;

  always_comb begin
    rgb        = (setup.mode == rpc_pkg::MODE_RGB);
    first4_nxt = '0;
    green4_nxt = '0;
    blue4_nxt  = '0;
    if (paint3_r) begin
      if (rgb) begin
        first4_nxt = setup.color[23:16];
        green4_nxt = setup.color[15:8];
        blue4_nxt  = setup.color[7:0];
      end else begin
        first4_nxt = luma3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      paint4_r <= paint3_r;
      first4_r <= first4_nxt;
      green4_r <= green4_nxt;
      blue4_r  <= blue4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_paint = paint4_r;
  assign out_first = first4_r;
  assign out_green = green4_r;
  assign out_blue  = blue4_r;

  a_clear_when_unpainted: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !paint4_r |-> (first4_r == 8'd0) && (green4_r == 8'd0) && (blue4_r == 8'd0))
    else $error("unpainted beat carries a value");

  a_gray_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && (setup.mode == rpc_pkg::MODE_GRAY) |-> (green4_r == 8'd0) && (blue4_r == 8'd0))
    else $error("gray beat carries green or blue");

  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy3 |=> v3_r)
    else $error("stalled stage 3 dropped its beat");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted beat missing from stage 1");

endmodule

`default_nettype wire

### src/rectangle_pixel_coverage.sv
// ---------------------------------------------------------------------------
// rectangle_pixel_coverage: per-pixel rectangle outline or fill test
// reports whether the configured rectangle paints a pixel and its value
// ---------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  in_      in   pixel_x[11:0], pixel_y[23:12]
//  out_     out  paint[0], value_first[8:1], value_green[16:9], value_blue[24:17]
//  cfg_     in   register index, write data (24 bit)
//
//  one beat per cycle sustained while out_tready stays high
//  the stages are input capture, box compare with luma products, hit merge
//  with luma sum, and the output register
//  a register write applies to beats accepted after it, with none in flight
//  reset holds in_tready low for one cycle after rst_n rises
//  each stage moves when the next one is empty or moving, so a stall at the
//  output fills bubbles before in_tready drops
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rectangle_pixel_coverage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [rpc_pkg::ADDR_W-1:0]  cfg_addr,
  input  wire logic [rpc_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [23:0]                 in_tdata,   // pixel_x, pixel_y
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata   // paint, value_first, value_green, value_blue
);

  rpc_pkg::rpc_setup_t setup;
  logic       paint;
  logic [7:0] first, green, blue;

  rpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .setup     (setup)
  );

  rpc_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .setup     (setup),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      (in_tdata[11:0]),
    .in_y      (in_tdata[23:12]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_paint (paint),
    .out_first (first),
    .out_green (green),
    .out_blue  (blue)
  );

  assign out_tdata = {7'd0, blue, green, first, paint};

endmodule

`default_nettype wire
